// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants for PUCT child selection
// Holds the field widths and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package pcs_pkg;

    localparam int VISIT_W  = 20;
    localparam int TOTAL_W  = 33;
    localparam int VLOSS_W  = 8;
    localparam int PRIOR_W  = 16;
    localparam int CPUCT_W  = 16;
    localparam int INDEX_W  = 8;
    localparam int SCORE_W  = 28;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;

    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 22;
    localparam int CPUCT_RESET = 5120;

    typedef struct packed {
        logic load;      // capture a word, start the mean divide and the root
        logic mul;       // latch the mean, form the exploration numerator
        logic start_u;   // start the exploration divide
        logic score;     // form the saturated score
        logic update;    // fold the score into the running best
        logic emit;      // load the result register and clear the scan
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/puct_child_select.sv =====
// ----------------------------------------------------------------------------
// puct_child_select: PUCT child selection over one streamed node
// Scores each child word and returns the best index and score on the last.
// ----------------------------------------------------------------------------
// Each child runs the 33-step shared divider twice, first for the mean and
// then for the exploration term; the 22-step root runs alongside the first.
// A child word is taken only in idle, once the previous child leaves its
// update step; the result register lets the next word enter while a result
// waits on the master side, and a last word holds in its update step until
// the waiting result drains.
// Reset: synchronous, active low; clears the scan, drops any waiting result
// word and sets c_puct to 1.25 (Q4.12).
`default_nettype none
module puct_child_select #(
    parameter int MAX_CHILDREN = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config: c_puct, unsigned Q4.12
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    // tdata, low bit up: node_visits[19:0], child_visits[39:20],
    // child_total_value[72:40], child_virtual_loss[80:73],
    // child_prior[96:81], zero fill [103:97]
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pcs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    // tdata, low bit up: best_index[7:0], best_score[35:8], zero fill [39:36]
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pcs_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import pcs_pkg::*;

    logic [CPUCT_W-1:0]        r_c_puct;
    t_cmd                      cmd;
    t_sts                      sts;
    logic [INDEX_W-1:0]        best_index;
    logic signed [SCORE_W-1:0] best_score;

    // config is only to be written while idle; the block does not enforce this, so always take it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_puct <= CPUCT_W'(CPUCT_RESET);
        end else if (i_cfg_valid) begin
            r_c_puct <= i_cfg_data;
        end
    end

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcs_dpath #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_c_puct             (r_c_puct),
        .i_node_visits        (s_axis_tdata[19:0]),
        .i_child_visits       (s_axis_tdata[39:20]),
        .i_child_total_value  (s_axis_tdata[72:40]),
        .i_child_virtual_loss (s_axis_tdata[80:73]),
        .i_child_prior        (s_axis_tdata[96:81]),
        .i_last_child         (s_axis_tlast),
        .i_out_ready          (m_axis_tready),
        .o_out_valid          (m_axis_tvalid),
        .o_best_index         (best_index),
        .o_best_score         (best_score)
    );

    // pack the result word
    assign m_axis_tdata = {4'b0, best_score, best_index};

endmodule
`default_nettype wire

// ===== design/pcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcs_ctrl: sequencer for one child
// Steps the datapath through divide and root together, multiply, divide, score, update.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pcs_pkg::t_sts i_sts,
    output pcs_pkg::t_cmd      o_cmd
);
    import pcs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CALC_Q = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_LOAD_U = 7'b0001000,
        ST_CALC_U = 7'b0010000,
        ST_SCORE  = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CALC_Q;
                end
            end
            ST_CALC_Q: begin
                if (i_sts.div_done && i_sts.sqrt_done) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LOAD_U;
            end
            ST_LOAD_U: begin
                o_cmd.start_u = 1'b1;
                n_state       = ST_CALC_U;
            end
            ST_CALC_U: begin
                if (i_sts.div_done) n_state = ST_SCORE;
            end
            ST_SCORE: begin
                o_cmd.score = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                // on a last child, hold here while the previous result is still waiting
                if (!i_sts.last || i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    o_cmd.emit   = i_sts.last;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/pcs_dpath.sv =====
// ----------------------------------------------------------------------------
// pcs_dpath: arithmetic and scan state
// Shared restoring divider, digit-serial square root, two multipliers,
// score saturation, running best and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_dpath #(
    parameter int MAX_CHILDREN = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pcs_pkg::t_cmd                       i_cmd,
    output pcs_pkg::t_sts                            o_sts,
    input  wire logic [pcs_pkg::CPUCT_W-1:0]         i_c_puct,
    input  wire logic [pcs_pkg::VISIT_W-1:0]         i_node_visits,
    input  wire logic [pcs_pkg::VISIT_W-1:0]         i_child_visits,
    input  wire logic signed [pcs_pkg::TOTAL_W-1:0]  i_child_total_value,
    input  wire logic [pcs_pkg::VLOSS_W-1:0]         i_child_virtual_loss,
    input  wire logic [pcs_pkg::PRIOR_W-1:0]         i_child_prior,
    input  wire logic                                i_last_child,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [pcs_pkg::INDEX_W-1:0]              o_best_index,
    output logic signed [pcs_pkg::SCORE_W-1:0]       o_best_score
);
    import pcs_pkg::*;

    localparam int IW = $clog2(MAX_CHILDREN + 1);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_CHILDREN);
    localparam logic signed [35:0] SAT_HI = 36'sd134217727;
    localparam logic signed [35:0] SAT_LO = -36'sd134217728;

    // captured word
    logic [VISIT_W-1:0]  r_n;
    logic                r_neg;
    logic [VLOSS_W-1:0]  r_vl;
    logic                r_last;
    logic [31:0]         r_cp;

    // divider
    logic [32:0] r_dv_dd;
    logic [21:0] r_dv_rem;
    logic [20:0] r_dv_den;
    logic [5:0]  r_dv_cnt;
    logic [21:0] dv_sh;
    logic        dv_ge;

    // square root
    logic [43:0] r_sq_x;
    logic [24:0] r_sq_rem;
    logic [21:0] r_sq_root;
    logic [4:0]  r_sq_cnt;
    logic [24:0] sq_sh;
    logic [24:0] sq_trial;
    logic        sq_ge;

    logic signed [33:0] r_q;
    logic [53:0]        r_num;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [35:0] sum;
    logic signed [SCORE_W-1:0] sat;

    logic [IW-1:0]             r_next_idx;
    logic                      r_have;
    logic [INDEX_W-1:0]        r_best_idx;
    logic signed [SCORE_W-1:0] r_best;
    logic                      take;
    logic [INDEX_W-1:0]        nb_idx;
    logic signed [SCORE_W-1:0] nb_score;
    logic [IW+INDEX_W-1:0]     idx_ext;
    logic [TOTAL_W-1:0]        tv_mag;

    assign tv_mag   = i_child_total_value[TOTAL_W-1] ? TOTAL_W'(-i_child_total_value)
                                                     : i_child_total_value;
    assign dv_sh    = {r_dv_rem[20:0], r_dv_dd[32]};
    assign dv_ge    = dv_sh >= {1'b0, r_dv_den};
    assign sq_sh    = {r_sq_rem[22:0], r_sq_x[43:42]};
    assign sq_trial = {1'b0, r_sq_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign sum = $signed({{2{r_q[33]}}, r_q})
               - $signed({16'b0, r_vl, 12'b0})
               + $signed({10'b0, r_dv_dd[25:0]});
    assign sat = (sum > SAT_HI) ? SAT_HI[SCORE_W-1:0] :
                 (sum < SAT_LO) ? SAT_LO[SCORE_W-1:0] : sum[SCORE_W-1:0];

    assign idx_ext  = {{INDEX_W{1'b0}}, r_next_idx};
    assign take     = (r_next_idx < MAX_IDX) && (!r_have || r_score > r_best);
    assign nb_idx   = take ? idx_ext[INDEX_W-1:0] : r_best_idx;
    assign nb_score = take ? r_score : r_best;

    assign o_sts.div_done  = (r_dv_cnt == '0);
    assign o_sts.sqrt_done = (r_sq_cnt == '0);
    assign o_sts.last      = r_last;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_child_visits;
            r_neg  <= i_child_total_value[TOTAL_W-1];
            r_vl   <= i_child_virtual_loss;
            r_last <= i_last_child;
            r_cp   <= i_c_puct * i_child_prior;
        end
        if (i_cmd.mul) begin
            if (r_n == '0) begin
                r_q <= '0;
            end else if (r_neg) begin
                r_q <= -$signed({1'b0, r_dv_dd});
            end else begin
                r_q <= $signed({1'b0, r_dv_dd});
            end
            r_num <= r_cp * r_sq_root;
        end
        if (i_cmd.score) begin
            r_score <= sat;
        end
        // divider: load or step
        if (i_cmd.load) begin
            r_dv_dd  <= tv_mag;
            r_dv_rem <= '0;
            r_dv_den <= {1'b0, i_child_visits};
        end else if (i_cmd.start_u) begin
            r_dv_dd  <= {7'b0, r_num[53:28]};
            r_dv_rem <= '0;
            r_dv_den <= {1'b0, r_n} + 21'd1;
        end else if (r_dv_cnt != '0) begin
            r_dv_rem <= dv_ge ? (dv_sh - {1'b0, r_dv_den}) : dv_sh;
            r_dv_dd  <= {r_dv_dd[31:0], dv_ge};
        end
        // root: load or step
        if (i_cmd.load) begin
            r_sq_x    <= {i_node_visits, 24'b0};
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_cnt != '0) begin
            r_sq_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            r_sq_root <= {r_sq_root[20:0], sq_ge};
            r_sq_x    <= {r_sq_x[41:0], 2'b00};
        end
        if (i_cmd.emit) begin
            o_best_index <= nb_idx;
            o_best_score <= nb_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt    <= '0;
            r_sq_cnt    <= '0;
            r_next_idx  <= '0;
            r_have      <= 1'b0;
            r_best_idx  <= '0;
            r_best      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.start_u) begin
                r_dv_cnt <= 6'(DIV_STEPS);
            end else if (r_dv_cnt != '0) begin
                r_dv_cnt <= r_dv_cnt - 6'd1;
            end
            if (i_cmd.load) begin
                r_sq_cnt <= 5'(SQRT_STEPS);
            end else if (r_sq_cnt != '0) begin
                r_sq_cnt <= r_sq_cnt - 5'd1;
            end
            if (i_cmd.emit) begin
                r_next_idx <= '0;
                r_have     <= 1'b0;
                r_best_idx <= '0;
                r_best     <= '0;
            end else if (i_cmd.update && (r_next_idx < MAX_IDX)) begin
                r_next_idx <= r_next_idx + 1'b1;
                r_have     <= 1'b1;
                r_best_idx <= nb_idx;
                r_best     <= nb_score;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
